>>> hdl/sysex_wave_data_unpacker_macros.svh
// Assertion helpers used by the checker of the wave-data unpacker.
`ifndef SYSEX_WAVE_DATA_UNPACKER_MACROS_SVH
`define SYSEX_WAVE_DATA_UNPACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swdu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swdu: next-cycle check failed");

`endif

>>> hdl/swdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swdu_pkg;

  // Stream framing and header checks
  localparam logic [7:0] SYX_START    = 8'hF0;
  localparam logic [7:0] SYX_END      = 8'hF7;
  localparam logic [7:0] CHAN_MAX     = 8'h0F;
  localparam logic [7:0] WAVE_BANK_LO = 8'h02;
  localparam logic [7:0] WAVE_BANK_HI = 8'h11;

  // Register reset values
  localparam logic [6:0] MFR_ID_RST  = 7'h41;
  localparam logic [6:0] MODEL_ID_RST = 7'h10;
  localparam logic [6:0] DSET_CMD_RST = 7'h12;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ADDR_W      = 18;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned START_POS_W = 19;
  // Largest start position: bank 0x11, mid and low bytes 0xFF
  localparam int unsigned START_POS_MAX = 278655;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_PTR_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MFR_ID   = 2'd0,
    CFG_MODEL_ID = 2'd1,
    CFG_DSET_CMD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_MFR,
    PH_CHAN,
    PH_MODEL,
    PH_CMD,
    PH_ADDR_HI,
    PH_ADDR_MID,
    PH_ADDR_LO,
    PH_DATA
  } phase_e;

  typedef enum logic {
    OP_START,
    OP_PAIR
  } op_e;

  typedef struct packed {
    logic [CFG_W-1:0] mfr_id;
    logic [CFG_W-1:0] model_id;
    logic [CFG_W-1:0] dset_cmd;
  } cfg_t;

  // Command from the classifier: a start position or a packed sample word
  typedef struct packed {
    op_e                    op;
    logic [START_POS_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [WORD_W-1:0] sample_word;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/swdu_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swdu_in_if;
  import swdu_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swdu_out_if;
  import swdu_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/swdu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module swdu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire swdu_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  output logic               push_valid_o,
  output swdu_pkg::cmd_t     push_cmd_o
);
  import swdu_pkg::*;

  phase_e     phase_q, phase_d;
  logic       in_msg_q, in_msg_d;
  logic       is_dset_q, is_dset_d;
  logic       wave_q, wave_d;
  logic       pair_q, pair_d;
  logic [7:0] addr_hi_q, addr_hi_d;
  logic [7:0] addr_mid_q, addr_mid_d;
  logic [7:0] first_q, first_d;

  logic is_start, is_end, body;
  logic [3:0] bank;

  assign is_start = (byte_i == SYX_START);
  assign is_end   = (byte_i == SYX_END);
  assign body     = accept_i && in_msg_q && !is_start && !is_end;
  assign bank     = 4'(addr_hi_q - WAVE_BANK_LO);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i && is_start) begin
      phase_d = PH_MFR;
    end else if (body) begin
      case (phase_q)
        PH_MFR:      phase_d = PH_CHAN;
        PH_CHAN:     phase_d = PH_MODEL;
        PH_MODEL:    phase_d = PH_CMD;
        PH_CMD:      phase_d = PH_ADDR_HI;
        PH_ADDR_HI:  phase_d = PH_ADDR_MID;
        PH_ADDR_MID: phase_d = PH_ADDR_LO;
        PH_ADDR_LO:  phase_d = PH_DATA;
        PH_DATA:     phase_d = PH_DATA;
        default:     phase_d = PH_MFR;
      endcase
    end
  end

  // Message state and commands to the queue
  always_comb begin
    in_msg_d        = in_msg_q;
    is_dset_d       = is_dset_q;
    wave_d          = wave_q;
    pair_d          = pair_q;
    addr_hi_d       = addr_hi_q;
    addr_mid_d      = addr_mid_q;
    first_d         = first_q;
    push_valid_o    = 1'b0;
    push_cmd_o.op   = OP_PAIR;
    push_cmd_o.data = {3'b000, first_q[6:0], byte_i[6:2], 4'b0000};
    if (accept_i && is_start) begin
      in_msg_d  = 1'b1;
      is_dset_d = 1'b0;
      wave_d    = 1'b0;
    end else if (accept_i && is_end) begin
      in_msg_d = 1'b0;
    end else if (body) begin
      case (phase_q)
        PH_MFR: begin
          if (byte_i != {1'b0, cfg_i.mfr_id}) in_msg_d = 1'b0;
        end
        PH_CHAN: begin
          if (byte_i > CHAN_MAX) in_msg_d = 1'b0;
        end
        PH_MODEL: begin
          if (byte_i != {1'b0, cfg_i.model_id}) in_msg_d = 1'b0;
        end
        PH_CMD: begin
          is_dset_d = (byte_i == {1'b0, cfg_i.dset_cmd});
          if (byte_i != {1'b0, cfg_i.dset_cmd}) in_msg_d = 1'b0;
        end
        PH_ADDR_HI:  addr_hi_d  = byte_i;
        PH_ADDR_MID: addr_mid_d = byte_i;
        PH_ADDR_LO: begin
          if (addr_hi_q inside {[WAVE_BANK_LO:WAVE_BANK_HI]}) begin
            wave_d          = 1'b1;
            pair_d          = 1'b0;
            push_valid_o    = 1'b1;
            push_cmd_o.op   = OP_START;
            push_cmd_o.data = {1'b0, bank, 14'd0} + {4'd0, addr_mid_q, 7'd0}
                              + {11'd0, byte_i};
          end else begin
            wave_d = 1'b0;
          end
        end
        PH_DATA: begin
          if (is_dset_q && wave_q) begin
            if (!pair_q) begin
              first_d = byte_i;
              pair_d  = 1'b1;
            end else begin
              pair_d       = 1'b0;
              push_valid_o = 1'b1;
            end
          end
        end
        default: in_msg_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MFR;
      in_msg_q  <= 1'b0;
      is_dset_q <= 1'b0;
      wave_q    <= 1'b0;
      pair_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      in_msg_q  <= in_msg_d;
      is_dset_q <= is_dset_d;
      wave_q    <= wave_d;
      pair_q    <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_hi_q  <= addr_hi_d;
    addr_mid_q <= addr_mid_d;
    first_q    <= first_d;
  end

endmodule

`default_nettype wire

>>> hdl/swdu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module swdu_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  input  wire swdu_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output swdu_pkg::cmd_t pop_cmd_o,
  input  wire logic      pop_i
);
  import swdu_pkg::*;

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

>>> hdl/swdu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module swdu_back #(
  parameter int unsigned MEMORY_BYTES = 262144
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire swdu_pkg::cmd_t cmd_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  output swdu_pkg::result_t res_o,
  input  wire logic        res_ready_i
);
  import swdu_pkg::*;

  localparam int unsigned PosSpan =
    ((MEMORY_BYTES > START_POS_MAX) ? MEMORY_BYTES : START_POS_MAX) + 2;
  localparam int unsigned PosW = $clog2(PosSpan + 1);
  localparam logic [PosW:0] Limit = (PosW+1)'(MEMORY_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW:0]   pos_end;
  logic            halted_q, halted_d;
  logic            valid_q, valid_d;
  result_t         res_q, res_d;
  logic            slot_free, load;

  assign slot_free = !valid_q || res_ready_i;
  // Drop everything once halted; start commands need no output slot
  assign cmd_pop_o = cmd_valid_i && (halted_q || cmd_i.op == OP_START || slot_free);
  assign load      = cmd_pop_o && !halted_q && cmd_i.op == OP_PAIR;
  assign pos_end   = {1'b0, pos_q} + (PosW+1)'(2);

  always_comb begin
    pos_d    = pos_q;
    halted_d = halted_q;
    res_d    = res_q;
    valid_d  = valid_q && !res_ready_i;
    if (cmd_pop_o && !halted_q) begin
      case (cmd_i.op)
        OP_START: pos_d = PosW'(cmd_i.data);
        OP_PAIR: begin
          valid_d = 1'b1;
          if (pos_end > Limit) begin
            halted_d = 1'b1;
            res_d    = '{write_address: '0, sample_word: '0, overflow: 1'b1};
          end else begin
            res_d = '{write_address: pos_q[ADDR_W-1:0],
                      sample_word:   cmd_i.data[WORD_W-1:0],
                      overflow:      1'b0};
            pos_d = pos_end[PosW-1:0];
          end
        end
        default: pos_d = pos_q;
      endcase
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      halted_q <= halted_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (load) res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> hdl/sysex_wave_data_unpacker.sv
// Data path: a byte that completes a sample pair is written into the command queue; the
//   back end pops that command and loads its word into the output register.
// Throughput: one byte per cycle while the queue has room; the four-entry command queue and
//   the output register let the byte side run on while a result waits to be taken.
// Reset: rst_ni clears the message tracker, queue, halt flag and output valid at once and
//   reloads the header registers with 0x41, 0x10 and 0x12. Only reset leaves the halt.
`timescale 1ns / 1ps
`default_nettype none

module sysex_wave_data_unpacker #(
  parameter int unsigned MEMORY_BYTES = 262144
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [swdu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [swdu_pkg::CFG_W-1:0]   cfg_data_i,
  swdu_in_if.sink                           byte_i,
  swdu_out_if.source                        result_o
);
  import swdu_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic accept;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic head_valid, head_pop;
  cmd_t head_cmd;

  // Header match registers; an index past the list is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MFR_ID:   cfg_d.mfr_id   = cfg_data_i;
        CFG_MODEL_ID: cfg_d.model_id = cfg_data_i;
        CFG_DSET_CMD: cfg_d.dset_cmd = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mfr_id: MFR_ID_RST, model_id: MODEL_ID_RST, dset_cmd: DSET_CMD_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a byte whenever the command queue has room
  assign byte_i.ready = push_ready;
  assign accept       = byte_i.valid && push_ready;

  // Front: track framing and header, emit start and pair commands
  swdu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .byte_i       (byte_i.data.in_byte),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  swdu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_cmd_o    (head_cmd),
    .pop_i        (head_pop)
  );

  // Back: hold the write position, check for overflow, drive the result register
  swdu_back #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .res_valid_o (result_o.valid),
    .res_o       (result_o.data),
    .res_ready_i (result_o.ready)
  );

endmodule

`default_nettype wire

>>> hdl/swdu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sysex_wave_data_unpacker_macros.svh"

module swdu_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire swdu_pkg::result_t out_data_i
);
  import swdu_pkg::*;

  logic taken, taken_ovf;
  logic ovf_shown, word_shown, ovf_clean, low_clear, stalled;

  assign taken      = out_valid_i && out_ready_i;
  assign taken_ovf  = taken && out_data_i.overflow;
  assign ovf_shown  = out_valid_i && out_data_i.overflow;
  assign word_shown = out_valid_i && !out_data_i.overflow;
  assign ovf_clean  = (out_data_i.write_address == '0) && (out_data_i.sample_word == '0);
  assign low_clear  = (out_data_i.sample_word[3:0] == 4'd0);
  assign stalled    = out_valid_i && !out_ready_i;

  `SWDU_ASSERT_NOW(a_ovf_zero, clk_i, rst_ni, ovf_shown, ovf_clean)
  `SWDU_ASSERT_NOW(a_word_low_bits, clk_i, rst_ni, word_shown, low_clear)
  `SWDU_ASSERT_NEXT(a_halt_after_ovf, clk_i, rst_ni, taken_ovf, !out_valid_i)
  `SWDU_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, stalled, out_valid_i && $stable(out_data_i))

endmodule

bind sysex_wave_data_unpacker swdu_props u_swdu_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

`default_nettype wire
